>>> rtl/itrd_pkg.sv
`timescale 1ns / 1ps
// itrd_pkg: constants, reciprocal table, state type and character mapping
// for the integer to radix text converter. No dependencies.
package itrd_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned COUNT_W     = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned INDEX_W     = $clog2(VALUE_WIDTH);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  CH_ZERO    = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0]  CH_ALPHA   = CHAR_W'(8'h41);
  localparam logic [CHAR_W-1:0]  CH_MINUS   = CHAR_W'(8'h2D);

  localparam longint unsigned SCALE = 64'd1 << VALUE_WIDTH;

  // floor(2^VALUE_WIDTH / r) for each legal radix
  localparam logic [VALUE_WIDTH-1:0] RECIP_TABLE [2:36] = '{
    VALUE_WIDTH'(SCALE / 64'd2),  VALUE_WIDTH'(SCALE / 64'd3),  VALUE_WIDTH'(SCALE / 64'd4),
    VALUE_WIDTH'(SCALE / 64'd5),  VALUE_WIDTH'(SCALE / 64'd6),  VALUE_WIDTH'(SCALE / 64'd7),
    VALUE_WIDTH'(SCALE / 64'd8),  VALUE_WIDTH'(SCALE / 64'd9),  VALUE_WIDTH'(SCALE / 64'd10),
    VALUE_WIDTH'(SCALE / 64'd11), VALUE_WIDTH'(SCALE / 64'd12), VALUE_WIDTH'(SCALE / 64'd13),
    VALUE_WIDTH'(SCALE / 64'd14), VALUE_WIDTH'(SCALE / 64'd15), VALUE_WIDTH'(SCALE / 64'd16),
    VALUE_WIDTH'(SCALE / 64'd17), VALUE_WIDTH'(SCALE / 64'd18), VALUE_WIDTH'(SCALE / 64'd19),
    VALUE_WIDTH'(SCALE / 64'd20), VALUE_WIDTH'(SCALE / 64'd21), VALUE_WIDTH'(SCALE / 64'd22),
    VALUE_WIDTH'(SCALE / 64'd23), VALUE_WIDTH'(SCALE / 64'd24), VALUE_WIDTH'(SCALE / 64'd25),
    VALUE_WIDTH'(SCALE / 64'd26), VALUE_WIDTH'(SCALE / 64'd27), VALUE_WIDTH'(SCALE / 64'd28),
    VALUE_WIDTH'(SCALE / 64'd29), VALUE_WIDTH'(SCALE / 64'd30), VALUE_WIDTH'(SCALE / 64'd31),
    VALUE_WIDTH'(SCALE / 64'd32), VALUE_WIDTH'(SCALE / 64'd33), VALUE_WIDTH'(SCALE / 64'd34),
    VALUE_WIDTH'(SCALE / 64'd35), VALUE_WIDTH'(SCALE / 64'd36)
  };

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_FIX  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_ALPHA + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

>>> rtl/integer_to_radix_digits_core.sv
`timescale 1ns / 1ps
// integer_to_radix_digits_core: signed integer to ASCII text in radix 2..36.
// Depends on itrd_pkg.
//
// A beat is taken when start_i is high and busy_o is low. The magnitude is
// split into digits least significant first by one shared multiplier: each
// digit is found in ST_MUL (multiply by a table reciprocal), then in ST_FIX
// (multiply the quotient back, subtract and correct by one). The text then
// leaves one character per cycle, sign first, on text_char_o/last_char_o
// marked by char_valid_o, which the receiver must take when shown. busy_o
// stays high from the accepted beat on and falls as the last character is shown.
module integer_to_radix_digits_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [itrd_pkg::VALUE_WIDTH-1:0]   value_i,
  input  logic [itrd_pkg::RADIX_W-1:0]       radix_i,
  output logic                               char_valid_o,
  output logic [itrd_pkg::CHAR_W-1:0]        text_char_o,
  output logic                               last_char_o
);
  import itrd_pkg::*;

  state_e                   state_q, state_d;
  logic [VALUE_WIDTH-1:0]   mag_q, mag_d;
  logic [VALUE_WIDTH-1:0]   recip_q;
  logic [VALUE_WIDTH-1:0]   prod_hi_q;
  logic [RADIX_W-1:0]       radix_q;
  logic                     neg_q, neg_d;
  logic [COUNT_W-1:0]       cnt_q, cnt_d;
  logic [DIGIT_W-1:0]       digits_q [VALUE_WIDTH];
  logic                     valid_q, valid_d;
  logic [CHAR_W-1:0]        char_q, char_d;
  logic                     last_q, last_d;

  logic [RADIX_W-1:0]       radix_clamp;
  logic [VALUE_WIDTH-1:0]   mul_a, mul_b;
  logic [2*VALUE_WIDTH-1:0] mul_p;
  logic [VALUE_WIDTH-1:0]   rem0;
  logic                     corr;
  logic [VALUE_WIDTH-1:0]   rem_fix;
  logic [DIGIT_W-1:0]       digit;
  logic [VALUE_WIDTH-1:0]   quot;
  logic [COUNT_W-1:0]       rd_cnt;
  logic                     accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    if (radix_i < RADIX_MIN) begin
      radix_clamp = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      radix_clamp = RADIX_MAX;
    end else begin
      radix_clamp = radix_i;
    end
  end

  // shared multiplier: reciprocal step, then back-multiply step
  assign mul_a = (state_q == ST_MUL) ? mag_q : prod_hi_q;
  assign mul_b = (state_q == ST_MUL) ? recip_q : VALUE_WIDTH'(radix_q);
  assign mul_p = mul_a * mul_b;

  assign rem0    = mag_q - mul_p[VALUE_WIDTH-1:0];
  assign corr    = (rem0 >= VALUE_WIDTH'(radix_q));
  assign rem_fix = corr ? (rem0 - VALUE_WIDTH'(radix_q)) : rem0;
  assign digit   = rem_fix[DIGIT_W-1:0];
  assign quot    = prod_hi_q + VALUE_WIDTH'(corr);
  assign rd_cnt  = cnt_q - COUNT_W'(1);

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    valid_d = 1'b0;
    char_d  = char_q;
    last_d  = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          neg_d   = value_i[VALUE_WIDTH-1];
          mag_d   = value_i[VALUE_WIDTH-1] ? (~value_i + VALUE_WIDTH'(1)) : value_i;
          cnt_d   = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_FIX;
      end
      ST_FIX: begin
        mag_d = quot;
        cnt_d = cnt_q + COUNT_W'(1);
        if (quot == '0) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_EMIT: begin
        valid_d = 1'b1;
        if (neg_q) begin
          char_d = CH_MINUS;
          last_d = 1'b0;
          neg_d  = 1'b0;
        end else begin
          char_d = digit_char(digits_q[rd_cnt[INDEX_W-1:0]]);
          last_d = (rd_cnt == '0);
          cnt_d  = rd_cnt;
          if (rd_cnt == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      neg_q   <= neg_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
    if (accept) begin
      radix_q <= radix_clamp;
      recip_q <= RECIP_TABLE[radix_clamp];
    end
    if (state_q == ST_MUL) begin
      prod_hi_q <= mul_p[2*VALUE_WIDTH-1:VALUE_WIDTH];
    end
    if (state_q == ST_FIX) begin
      digits_q[cnt_q[INDEX_W-1:0]] <= digit;
    end
  end

  assign char_valid_o = valid_q;
  assign text_char_o  = char_q;
  assign last_char_o  = last_q;

endmodule

>>> dv/integer_to_radix_digits_checker.sv
`timescale 1ns / 1ps
// integer_to_radix_digits_checker: watches the command and character channels
// of integer_to_radix_digits_core, predicts the text of every accepted beat and
// compares each character in order. Depends on itrd_pkg for the port widths.
module integer_to_radix_digits_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic [itrd_pkg::VALUE_WIDTH-1:0] value_i,
  input  logic [itrd_pkg::RADIX_W-1:0]     radix_i,
  input  logic                             char_valid_i,
  input  logic [itrd_pkg::CHAR_W-1:0]      text_char_i,
  input  logic                             last_char_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  localparam int unsigned VW = itrd_pkg::VALUE_WIDTH;
  localparam int unsigned RW = itrd_pkg::RADIX_W;
  localparam int unsigned CW = itrd_pkg::CHAR_W;

  localparam logic [CW-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CW-1:0] ASCII_UPPER = 7'h41;
  localparam logic [CW-1:0] ASCII_MINUS = 7'h2D;
  localparam logic [RW-1:0] BASE_LO     = 6'd2;
  localparam logic [RW-1:0] BASE_HI     = 6'd36;

  typedef struct packed {
    logic [CW-1:0] ch;
    logic          last;
  } text_beat_t;

  text_beat_t text_q[$];
  int         err_cnt;

  function automatic logic [CW-1:0] glyph_of(input logic [RW-1:0] d);
    logic [CW-1:0] c;
    if (d < 6'd10) begin
      c = ASCII_ZERO + CW'(d);
    end else begin
      c = ASCII_UPPER + CW'(d - 6'd10);
    end
    return c;
  endfunction

  function automatic void queue_text(input logic [VW-1:0] value, input logic [RW-1:0] radix);
    logic [VW-1:0] mag;
    logic [RW-1:0] base;
    logic [RW-1:0] digs[$];
    text_beat_t    b;
    int            i;
    base = radix;
    if (base < BASE_LO) base = BASE_LO;
    if (base > BASE_HI) base = BASE_HI;
    mag = value[VW-1] ? (~value + VW'(1)) : value;
    do begin
      digs.push_back(RW'(mag % VW'(base)));
      mag = mag / VW'(base);
    end while (mag != '0);
    if (value[VW-1]) begin
      b.ch   = ASCII_MINUS;
      b.last = 1'b0;
      text_q.push_back(b);
    end
    for (i = digs.size() - 1; i >= 0; i--) begin
      b.ch   = glyph_of(digs[i]);
      b.last = (i == 0);
      text_q.push_back(b);
    end
  endfunction

  always @(posedge clk_i) begin
    text_beat_t want;
    if (rst_ni) begin
      if (char_valid_i) begin
        if (text_q.size() == 0) begin
          if (err_cnt < 10)
            $display("[%0t] unexpected char 0x%02h last=%0b", $time, text_char_i, last_char_i);
          err_cnt++;
        end else begin
          want = text_q.pop_front();
          if (text_char_i !== want.ch || last_char_i !== want.last) begin
            if (err_cnt < 10)
              $display("[%0t] char mismatch: exp 0x%02h last=%0b, got 0x%02h last=%0b",
                       $time, want.ch, want.last, text_char_i, last_char_i);
            err_cnt++;
          end
        end
      end
      if (start_i && !busy_i) queue_text(value_i, radix_i);
    end
    fail_count_o <= err_cnt;
    pending_o    <= text_q.size();
  end

endmodule

>>> dv/integer_to_radix_digits_core_tb.sv
`timescale 1ns / 1ps
// integer_to_radix_digits_core_tb: drives directed and random conversion beats
// into integer_to_radix_digits_core and gives the verdict from the checker.
// Depends on itrd_pkg and integer_to_radix_digits_checker.
module integer_to_radix_digits_core_tb;

  localparam int unsigned VW        = itrd_pkg::VALUE_WIDTH;
  localparam int unsigned RW        = itrd_pkg::RADIX_W;
  localparam int          N_RANDOM  = 460;
  localparam int          TAIL      = 120;
  localparam longint      CYC_LIMIT = 400000;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic [VW-1:0]              value_i;
  logic [RW-1:0]              radix_i;
  logic                       char_valid_o;
  logic [itrd_pkg::CHAR_W-1:0] text_char_o;
  logic                       last_char_o;
  int                         fail_count;
  int                         pending;
  longint                     cycles;

  integer_to_radix_digits_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .value_i      (value_i),
    .radix_i      (radix_i),
    .char_valid_o (char_valid_o),
    .text_char_o  (text_char_o),
    .last_char_o  (last_char_o)
  );

  integer_to_radix_digits_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .value_i      (value_i),
    .radix_i      (radix_i),
    .char_valid_i (char_valid_o),
    .text_char_i  (text_char_o),
    .last_char_i  (last_char_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("FAIL integer_to_radix_digits_core");
      $finish;
    end
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    if (sel < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [RW-1:0] pick_radix();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return RW'($urandom_range(0, 1));
    if (sel == 1) return RW'($urandom_range(37, 63));
    return RW'($urandom_range(2, 36));
  endfunction

  function automatic logic [VW-1:0] pick_value(input logic [RW-1:0] radix);
    logic [VW-1:0] v;
    longint        p;
    longint        base;
    int            k;
    base = (radix < 2) ? 2 : (radix > 36) ? 36 : radix;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3, 4:    v = VW'($urandom_range(0, 100));
      5: begin
        v = $urandom_range(0, 1) ? {1'b0, {(VW-1){1'b1}}} : {1'b1, {(VW-1){1'b0}}};
        v = v + VW'($urandom_range(0, 4)) - VW'(2);
      end
      6: begin
        p = 1;
        k = $urandom_range(1, 31);
        repeat (k) if (p * base <= (64'd1 << (VW - 1))) p = p * base;
        v = VW'(p) + VW'($urandom_range(0, 2)) - VW'(1);
      end
      7: v = VW'(1) << $urandom_range(0, VW - 1);
      default: v = $urandom >> $urandom_range(0, VW - 1);
    endcase
    if (($urandom_range(0, 1) == 1) && (v[VW-1] == 1'b0)) v = ~v + VW'(1);
    return v;
  endfunction

  // enter and leave on a falling edge
  task automatic send_number(input logic [VW-1:0] v, input logic [RW-1:0] r, input int gap);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) begin
        value_i = $urandom;
        radix_i = RW'($urandom);
        @(negedge clk_i);
      end
    end
    start_i = 1'b1;
    value_i = v;
    radix_i = r;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  initial begin
    logic [RW-1:0] r;
    int            i;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    value_i = '0;
    radix_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_number(32'd0, 6'd10, 0);
    send_number(32'd1, 6'd10, 0);
    send_number(32'hFFFF_FFFF, 6'd10, 1);
    send_number(32'h7FFF_FFFF, 6'd10, 0);
    send_number(32'h8000_0000, 6'd10, 0);
    send_number(32'h8000_0000, 6'd2, 2);
    send_number(32'h8000_0000, 6'd36, 0);
    send_number(32'h7FFF_FFFF, 6'd2, 0);
    send_number(32'h7FFF_FFFF, 6'd36, 0);
    send_number(32'd0, 6'd0, 3);
    send_number(32'd255, 6'd1, 0);
    send_number(-32'sd255, 6'd37, 0);
    send_number(32'd1295, 6'd63, 0);
    send_number(32'd35, 6'd36, 0);
    send_number(32'd10, 6'd11, 0);
    send_number(32'hDEAD_BEEF, 6'd16, 5);
    send_number(32'd9, 6'd10, 0);
    send_number(-32'sd1, 6'd2, 0);
    send_number(32'd0, 6'd63, 0);
    send_number(32'hAAAA_AAAA, 6'd8, 0);
    send_number(32'h5555_5555, 6'd3, 0);
    send_number(32'd123456789, 6'd7, 40);

    for (i = 0; i < N_RANDOM; i++) begin
      r = pick_radix();
      send_number(pick_value(r), r, pick_gap());
    end
    start_i = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS integer_to_radix_digits_core");
    end else begin
      $display("FAIL integer_to_radix_digits_core");
    end
    $finish;
  end

endmodule
